// File: rtl/core/quantized_vector_distance_assert.svh
// ----------------------------------------------------------------------------
// quantized vector distance assertion macros
// immediate-implication and next-cycle-implication property wrappers
// ----------------------------------------------------------------------------
`ifndef QUANTIZED_VECTOR_DISTANCE_ASSERT_SVH
`define QUANTIZED_VECTOR_DISTANCE_ASSERT_SVH

// pre implies post in the same cycle
`define QVD_ASSERT_NOW(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |-> (post)) \
    else $error(msg);

// pre implies post in the following cycle
`define QVD_ASSERT_NEXT(label, clk_s, rst_s, pre, post, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/qvd_pkg.sv
// ----------------------------------------------------------------------------
// qvd_pkg
// widths, register indexes, codes and sequencer types of the distance block
// ----------------------------------------------------------------------------
package qvd_pkg;

  localparam int VALUE_W    = 16;
  localparam int SCALE_W    = 32;
  localparam int NORM_W     = 42;
  localparam int DIST_W     = 48;
  localparam int ACC_W      = 43;
  localparam int WIDE_W     = 110;
  localparam int PROD_W     = 64;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_WIDTH = 1'd1;

  localparam logic [1:0] METRIC_COSINE    = 2'd0;
  localparam logic [1:0] METRIC_EUCLID    = 2'd1;
  localparam logic [1:0] METRIC_SQ_EUCLID = 2'd2;

  localparam logic EW_INT8  = 1'b0;
  localparam logic EW_INT16 = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SQ,
    ST_MAC,
    ST_DRAIN,
    ST_FIN,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_CROSS
  } phase_t;

endpackage

// File: rtl/core/qvd_elem_if.sv
// ----------------------------------------------------------------------------
// qvd_elem_if
// element pair request channel with closing scales and norms
// ----------------------------------------------------------------------------
interface qvd_elem_if;
  logic                                valid;
  logic                                ready;
  logic signed [qvd_pkg::VALUE_W-1:0]  left_value;
  logic signed [qvd_pkg::VALUE_W-1:0]  right_value;
  logic                                last_element;
  logic        [qvd_pkg::SCALE_W-1:0]  left_scale;
  logic        [qvd_pkg::SCALE_W-1:0]  right_scale;
  logic        [qvd_pkg::NORM_W-1:0]   left_norm_sq;
  logic        [qvd_pkg::NORM_W-1:0]   right_norm_sq;

  modport source (
    output valid, left_value, right_value, last_element,
           left_scale, right_scale, left_norm_sq, right_norm_sq,
    input  ready
  );

  modport sink (
    input  valid, left_value, right_value, last_element,
           left_scale, right_scale, left_norm_sq, right_norm_sq,
    output ready
  );
endinterface

// File: rtl/core/qvd_result_if.sv
// ----------------------------------------------------------------------------
// qvd_result_if
// distance result channel
// ----------------------------------------------------------------------------
interface qvd_result_if;
  logic                         valid;
  logic                         ready;
  logic [qvd_pkg::DIST_W-1:0]   distance;

  modport source (output valid, distance, input ready);
  modport sink   (input valid, distance, output ready);
endinterface

// File: rtl/core/qvd_cfg_if.sv
// ----------------------------------------------------------------------------
// qvd_cfg_if
// configuration register write channel
// ----------------------------------------------------------------------------
interface qvd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [qvd_pkg::CFG_IDX_W-1:0]    index;
  logic [qvd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/quantized_vector_distance.sv
// ----------------------------------------------------------------------------
// quantized_vector_distance
// dot product of quantized vectors and cosine / euclidean distance
// ----------------------------------------------------------------------------
// elem carries one element pair per request; the block multiplies and adds
// it into the dot accumulator in the cycle it is taken, so plain element
// requests go in at one per cycle while the block is idle.
// a request with last_element set is accumulated, then the scales and norms
// are combined by one shared 32x32 multiplier feeding a 110-bit adder, one
// partial product per cycle; the euclidean root takes one bit per cycle.
// elem.ready is low from that closing request until the distance is handed
// to the output register, after which result.valid rises.
// result is a held output register: while the receiver stalls, element
// requests are still taken, and a further closing request waits at its end.
// cfg writes metric_mode (index 0) and element_width_mode (index 1), always
// ready, to be used only while the block is idle.
// rst (synchronous) clears dot_acc, the control registers and result.valid.
// ----------------------------------------------------------------------------
module quantized_vector_distance #(
  parameter int SCALE_FRAC_BITS = 24,
  parameter int DIST_FRAC_BITS  = 16
) (
  input  logic           clk,
  input  logic           rst,
  qvd_elem_if.sink       elem,
  qvd_result_if.source   result,
  qvd_cfg_if.sink        cfg
);

`include "quantized_vector_distance_assert.svh"

  localparam int VW   = qvd_pkg::VALUE_W;
  localparam int SW   = qvd_pkg::SCALE_W;
  localparam int NW   = qvd_pkg::NORM_W;
  localparam int DW   = qvd_pkg::DIST_W;
  localparam int AW   = qvd_pkg::ACC_W;
  localparam int WW   = qvd_pkg::WIDE_W;
  localparam int PW   = qvd_pkg::PROD_W;
  localparam int CW   = qvd_pkg::CNT_W;
  localparam int TWO_S  = 2 * SCALE_FRAC_BITS;
  localparam int TWO_D  = 2 * DIST_FRAC_BITS;
  localparam int SHL    = (DIST_FRAC_BITS > TWO_S) ? DIST_FRAC_BITS - TWO_S : 0;
  localparam int SHR    = (TWO_S > DIST_FRAC_BITS) ? TWO_S - DIST_FRAC_BITS : 0;
  localparam int RSHL   = (TWO_D > TWO_S) ? TWO_D - TWO_S : 0;
  localparam int RSHR   = (TWO_S > TWO_D) ? TWO_S - TWO_D : 0;
  localparam int SC_W   = WW + SHL;
  localparam int RT_W   = WW + RSHL;
  localparam logic [DW-1:0] DIST_ONE = DW'(1) << DIST_FRAC_BITS;
  localparam logic [DW-1:0] DIST_TWO = DW'(2) << DIST_FRAC_BITS;

  qvd_pkg::state_t state, state_next;
  qvd_pkg::phase_t phase;

  logic [1:0]              metric;
  logic                    ew;
  logic signed [AW-1:0]    dot_acc;
  logic [SW-1:0]           ls, rs;
  logic [NW-1:0]           ln, rn;
  logic [AW-1:0]           mag;
  logic                    neg;
  logic [PW-1:0]           sq;
  logic [1:0]              idx;
  logic                    pp_valid, pp_sub, pp_dbl;
  logic [1:0]              pp_shift;
  logic [PW-1:0]           pp;
  logic signed [WW-1:0]    acc;
  logic [DW-1:0]           res;
  logic [2*DW-1:0]         xs;
  logic [DW+1:0]           rem;
  logic [DW-1:0]           root;
  logic [CW-1:0]           cnt;
  logic                    out_valid;
  logic [DW-1:0]           out_dist;

  logic                    elem_take, out_load;
  logic signed [VW-1:0]    left_elem, right_elem;
  logic signed [2*VW-1:0]  elem_prod;
  logic signed [AW-1:0]    dot_sum;
  logic [SW-1:0]           mul_a, mul_b;
  logic [PW-1:0]           mul_p;
  logic [AW-1:0]           xsel;
  logic [WW-1:0]           pp_base, pp_shifted, pp_term;
  logic [WW-1:0]           vpos;
  logic [SC_W-1:0]         scaled;
  logic [RT_W-1:0]         xw;
  logic [DW-1:0]           dist_sq, simq, cos_dist;
  logic                    cos_sat, root_sat, scale_zero;
  logic [DW+1:0]           rem_sh, trial;
  logic                    rem_ge;
  logic [DW-1:0]           root_next;

  // element pair multiply-accumulate
  assign left_elem  = (ew == qvd_pkg::EW_INT16) ? elem.left_value
                    : {{(VW-8){elem.left_value[7]}}, elem.left_value[7:0]};
  assign right_elem = (ew == qvd_pkg::EW_INT16) ? elem.right_value
                    : {{(VW-8){elem.right_value[7]}}, elem.right_value[7:0]};
  assign elem_prod  = left_elem * right_elem;
  assign dot_sum    = dot_acc + AW'(elem_prod);

  assign elem_take  = elem.valid && elem.ready;
  assign elem.ready = (state == qvd_pkg::ST_IDLE);
  assign cfg.ready  = 1'b1;

  assign result.valid    = out_valid;
  assign result.distance = out_dist;

  // shared multiplier operands
  always_comb begin
    case (phase)
      qvd_pkg::PH_LEFT:  xsel = AW'(ln);
      qvd_pkg::PH_RIGHT: xsel = AW'(rn);
      default:           xsel = mag;
    endcase
  end

  always_comb begin
    mul_a = ls;
    mul_b = rs;
    case (state)
      qvd_pkg::ST_SQ: begin
        case (phase)
          qvd_pkg::PH_LEFT: begin
            mul_a = ls;
            mul_b = ls;
          end
          qvd_pkg::PH_RIGHT: begin
            mul_a = rs;
            mul_b = rs;
          end
          default: begin
            mul_a = ls;
            mul_b = rs;
          end
        endcase
      end
      qvd_pkg::ST_MAC: begin
        mul_a = idx[0] ? sq[PW-1:SW] : sq[SW-1:0];
        mul_b = idx[1] ? SW'(xsel[AW-1:SW]) : xsel[SW-1:0];
      end
      default: begin
        mul_a = ls;
        mul_b = rs;
      end
    endcase
  end

  assign mul_p = {{(PW-SW){1'b0}}, mul_a} * {{(PW-SW){1'b0}}, mul_b};

  // partial product alignment
  assign pp_base = WW'(pp);
  always_comb begin
    case (pp_shift)
      2'd0:    pp_shifted = pp_base;
      2'd1:    pp_shifted = pp_base << SW;
      default: pp_shifted = pp_base << (2 * SW);
    endcase
  end
  assign pp_term = pp_dbl ? (pp_shifted << 1) : pp_shifted;

  // final scaling and saturation
  assign vpos       = acc[WW-1] ? '0 : acc;
  assign scaled     = (SC_W'(vpos) << SHL) >> SHR;
  assign dist_sq    = (scaled[SC_W-1:DW] != '0) ? '1 : scaled[DW-1:0];
  assign xw         = (RT_W'(vpos) << RSHL) >> RSHR;
  assign root_sat   = (xw[RT_W-1:2*DW] != '0);
  assign scale_zero = (ls == '0) || (rs == '0);
  assign cos_sat    = ((vpos >> TWO_S) != '0);
  assign simq       = cos_sat ? DIST_ONE : scaled[DW-1:0];
  assign cos_dist   = scale_zero ? DIST_ONE
                    : (neg ? DIST_ONE + simq : DIST_ONE - simq);

  // restoring square root, one bit per cycle
  assign rem_sh    = {rem[DW-1:0], xs[2*DW-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign rem_ge    = (rem_sh >= trial);
  assign root_next = {root[DW-2:0], rem_ge};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qvd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    out_load   = 1'b0;
    case (state)
      qvd_pkg::ST_IDLE: begin
        if (elem_take && elem.last_element) begin
          state_next = qvd_pkg::ST_LOAD;
        end
      end
      qvd_pkg::ST_LOAD: state_next = qvd_pkg::ST_SQ;
      qvd_pkg::ST_SQ:   state_next = qvd_pkg::ST_MAC;
      qvd_pkg::ST_MAC: begin
        if (idx == 2'd3) begin
          state_next = (phase == qvd_pkg::PH_CROSS) ? qvd_pkg::ST_DRAIN : qvd_pkg::ST_SQ;
        end
      end
      qvd_pkg::ST_DRAIN: state_next = qvd_pkg::ST_FIN;
      qvd_pkg::ST_FIN: begin
        if (metric == qvd_pkg::METRIC_EUCLID && !root_sat) begin
          state_next = qvd_pkg::ST_ROOT;
        end else begin
          state_next = qvd_pkg::ST_DONE;
        end
      end
      qvd_pkg::ST_ROOT: begin
        if (cnt == '0) begin
          state_next = qvd_pkg::ST_DONE;
        end
      end
      qvd_pkg::ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = qvd_pkg::ST_IDLE;
        end
      end
      default: state_next = qvd_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      metric    <= qvd_pkg::METRIC_COSINE;
      ew        <= qvd_pkg::EW_INT8;
      dot_acc   <= '0;
      out_valid <= 1'b0;
      pp_valid  <= 1'b0;
      phase     <= qvd_pkg::PH_LEFT;
      idx       <= '0;
      cnt       <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          qvd_pkg::REG_METRIC_MODE:   metric <= cfg.data;
          qvd_pkg::REG_ELEMENT_WIDTH: ew     <= cfg.data[0];
          default: ;
        endcase
      end

      if (state == qvd_pkg::ST_LOAD) begin
        dot_acc <= '0;
      end else if (elem_take) begin
        dot_acc <= dot_sum;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      pp_valid <= (state == qvd_pkg::ST_MAC);

      case (state)
        qvd_pkg::ST_LOAD: begin
          phase <= (metric == qvd_pkg::METRIC_COSINE) ? qvd_pkg::PH_CROSS : qvd_pkg::PH_LEFT;
        end
        qvd_pkg::ST_SQ: idx <= '0;
        qvd_pkg::ST_MAC: begin
          idx <= idx + 2'd1;
          if (idx == 2'd3) begin
            case (phase)
              qvd_pkg::PH_LEFT:  phase <= qvd_pkg::PH_RIGHT;
              qvd_pkg::PH_RIGHT: phase <= qvd_pkg::PH_CROSS;
              default:           phase <= qvd_pkg::PH_CROSS;
            endcase
          end
        end
        qvd_pkg::ST_FIN:  cnt <= CW'(DW - 1);
        qvd_pkg::ST_ROOT: cnt <= cnt - CW'(1);
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == qvd_pkg::ST_IDLE && elem_take && elem.last_element) begin
      ls <= elem.left_scale;
      rs <= elem.right_scale;
      ln <= elem.left_norm_sq;
      rn <= elem.right_norm_sq;
    end

    if (state == qvd_pkg::ST_LOAD) begin
      neg <= dot_acc[AW-1];
      mag <= dot_acc[AW-1] ? AW'(-dot_acc) : AW'(dot_acc);
      acc <= '0;
    end else if (pp_valid) begin
      acc <= pp_sub ? acc - signed'(pp_term) : acc + signed'(pp_term);
    end

    if (state == qvd_pkg::ST_SQ) begin
      sq <= mul_p;
    end

    if (state == qvd_pkg::ST_MAC) begin
      pp       <= mul_p;
      pp_shift <= {1'b0, idx[0]} + {1'b0, idx[1]};
      pp_dbl   <= (phase == qvd_pkg::PH_CROSS) && (metric != qvd_pkg::METRIC_COSINE);
      pp_sub   <= (phase == qvd_pkg::PH_CROSS) && (metric != qvd_pkg::METRIC_COSINE) && !neg;
    end

    case (state)
      qvd_pkg::ST_FIN: begin
        xs   <= xw[2*DW-1:0];
        rem  <= '0;
        root <= '0;
        case (metric)
          qvd_pkg::METRIC_COSINE: res <= cos_dist;
          qvd_pkg::METRIC_EUCLID: res <= '1;
          default:                res <= dist_sq;
        endcase
      end
      qvd_pkg::ST_ROOT: begin
        xs   <= xs << 2;
        rem  <= rem_ge ? rem_sh - trial : rem_sh;
        root <= root_next;
        if (cnt == '0) begin
          res <= root_next;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_dist <= res;
    end
  end

  `QVD_ASSERT_NEXT(a_last_load, clk, rst, elem.valid && elem.ready && elem.last_element, state == qvd_pkg::ST_LOAD, "closing request did not start the sequence")
  `QVD_ASSERT_NEXT(a_out_load, clk, rst, out_load, result.valid && result.distance == $past(res), "distance not presented after load")
  `QVD_ASSERT_NEXT(a_cos_range, clk, rst, state == qvd_pkg::ST_FIN && metric == qvd_pkg::METRIC_COSINE, res <= DIST_TWO, "cosine distance above two")
  `QVD_ASSERT_NOW(a_root_cnt, clk, rst, state == qvd_pkg::ST_ROOT, cnt < CW'(DW), "root bit counter out of range")

endmodule
